[rtl/cssim_pkg.sv]
// Shared widths, constants and types of the cosine similarity stream core.
package cssim_pkg;

  localparam int InW           = 16;
  localparam int InDataW       = 2 * InW;
  localparam int DefSampleBits = 16;
  localparam int DefQueueDepth = 2;
  localparam int AccW          = 48;
  localparam int ProdW         = 2 * AccW;
  localparam int ResW          = 16;
  localparam int RootW         = ResW;
  localparam int QuoW          = 2 * RootW;
  localparam int CntW          = $clog2(AccW);

  localparam logic [AccW-1:0] AccMax = {1'b0, {(AccW-1){1'b1}}};
  localparam logic [AccW-1:0] AccMin = {1'b1, {(AccW-1){1'b0}}};
  localparam logic [ResW-1:0] ResMax = {1'b0, {(ResW-1){1'b1}}};
  localparam logic [ResW-1:0] ResOne = {1'b1, {(ResW-1){1'b0}}};

  typedef struct packed {
    logic signed [AccW-1:0] dot;
    logic [AccW-1:0]        sq_a;
    logic [AccW-1:0]        sq_b;
  } acc_set_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_DOT,
    ST_MUL_NORM,
    ST_CHECK,
    ST_DIV,
    ST_SQRT,
    ST_FIN
  } back_state_t;

endpackage

[rtl/cssim_front.sv]
// Front end: multiplies each element pair and keeps the saturating running sums.
module cssim_front #(
  parameter int SAMPLE_BITS = cssim_pkg::DefSampleBits
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [cssim_pkg::InDataW-1:0] in_tdata,
  input  logic                        in_tlast,
  input  logic                        q_wr_ready,
  output logic                        q_wr_en,
  output cssim_pkg::acc_set_t         q_wr_data
);
  import cssim_pkg::*;

  localparam int ExtW = (SAMPLE_BITS > InW) ? SAMPLE_BITS : InW;
  localparam int PW   = 2 * SAMPLE_BITS;

  logic [ExtW-1:0]               ext_a;
  logic [ExtW-1:0]               ext_b;
  logic signed [SAMPLE_BITS-1:0] smp_a;
  logic signed [SAMPLE_BITS-1:0] smp_b;
  logic                          in_acc;
  logic                          p_adv;
  logic                          p_valid_r;
  logic                          p_valid_nxt;
  logic                          p_last_r;
  logic signed [PW-1:0]          p_dot_r;
  logic [PW-1:0]                 p_sqa_r;
  logic [PW-1:0]                 p_sqb_r;
  logic signed [AccW-1:0]        dot_r;
  logic signed [AccW-1:0]        dot_nxt;
  logic [AccW-1:0]               sqa_r;
  logic [AccW-1:0]               sqa_nxt;
  logic [AccW-1:0]               sqb_r;
  logic [AccW-1:0]               sqb_nxt;
  logic signed [AccW:0]          dot_sum;
  logic [AccW:0]                 sqa_sum;
  logic [AccW:0]                 sqb_sum;
  logic signed [AccW-1:0]        dot_sat;
  logic [AccW-1:0]               sqa_sat;
  logic [AccW-1:0]               sqb_sat;

  assign ext_a = ExtW'(in_tdata[InW-1:0]);
  assign ext_b = ExtW'(in_tdata[InDataW-1:InW]);
  assign smp_a = signed'(ext_a[SAMPLE_BITS-1:0]);
  assign smp_b = signed'(ext_b[SAMPLE_BITS-1:0]);

  assign p_adv     = p_valid_r && (!p_last_r || q_wr_ready);
  assign in_tready = !p_valid_r || p_adv;
  assign in_acc    = in_tvalid && in_tready;

  assign dot_sum = (AccW+1)'(dot_r) + (AccW+1)'(p_dot_r);
  assign sqa_sum = (AccW+1)'(sqa_r) + (AccW+1)'(p_sqa_r);
  assign sqb_sum = (AccW+1)'(sqb_r) + (AccW+1)'(p_sqb_r);

  always_comb begin
    if (dot_sum[AccW] != dot_sum[AccW-1]) begin
      dot_sat = dot_sum[AccW] ? signed'(AccMin) : signed'(AccMax);
    end else begin
      dot_sat = dot_sum[AccW-1:0];
    end
    sqa_sat = (sqa_sum > (AccW+1)'(AccMax)) ? AccMax : sqa_sum[AccW-1:0];
    sqb_sat = (sqb_sum > (AccW+1)'(AccMax)) ? AccMax : sqb_sum[AccW-1:0];
  end

  always_comb begin
    p_valid_nxt = p_valid_r;
    if (in_acc) begin
      p_valid_nxt = 1'b1;
    end else if (p_adv) begin
      p_valid_nxt = 1'b0;
    end
    dot_nxt = dot_r;
    sqa_nxt = sqa_r;
    sqb_nxt = sqb_r;
    if (p_adv) begin
      if (p_last_r) begin
        dot_nxt = '0;
        sqa_nxt = '0;
        sqb_nxt = '0;
      end else begin
        dot_nxt = dot_sat;
        sqa_nxt = sqa_sat;
        sqb_nxt = sqb_sat;
      end
    end
  end

  assign q_wr_en        = p_adv && p_last_r;
  assign q_wr_data.dot  = dot_sat;
  assign q_wr_data.sq_a = sqa_sat;
  assign q_wr_data.sq_b = sqb_sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
      dot_r     <= '0;
      sqa_r     <= '0;
      sqb_r     <= '0;
    end else begin
      p_valid_r <= p_valid_nxt;
      dot_r     <= dot_nxt;
      sqa_r     <= sqa_nxt;
      sqb_r     <= sqb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      p_last_r <= in_tlast;
      p_dot_r  <= PW'(smp_a) * PW'(smp_b);
      p_sqa_r  <= $unsigned(PW'(smp_a) * PW'(smp_a));
      p_sqb_r  <= $unsigned(PW'(smp_b) * PW'(smp_b));
    end
  end

  a_clear_after_push: assert property (@(posedge clk) disable iff (!rst_n)
    q_wr_en |=> (dot_r == '0 && sqa_r == '0 && sqb_r == '0))
    else $error("Running sums not cleared after a vector was handed on.");

  a_stall_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (p_valid_r && p_last_r && !q_wr_ready))
    else $error("Input stalled without a final pair waiting on a full queue.");

  a_square_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (sqa_r[AccW-1] == 1'b0 && sqb_r[AccW-1] == 1'b0))
    else $error("Square sum exceeded its saturation limit.");

endmodule

[rtl/cssim_queue.sv]
// Short queue of finished vector sums between the front end and the back end.
module cssim_queue #(
  parameter int DEPTH = cssim_pkg::DefQueueDepth
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  cssim_pkg::acc_set_t wr_data,
  output logic                wr_ready,
  input  logic                rd_en,
  output cssim_pkg::acc_set_t rd_data,
  output logic                rd_valid
);
  import cssim_pkg::*;

  localparam int PtrW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FillW = $clog2(DEPTH + 1);

  acc_set_t         mem_r [DEPTH];
  logic [PtrW-1:0]  wr_ptr_r;
  logic [PtrW-1:0]  wr_ptr_nxt;
  logic [PtrW-1:0]  rd_ptr_r;
  logic [PtrW-1:0]  rd_ptr_nxt;
  logic [FillW-1:0] fill_r;
  logic [FillW-1:0] fill_nxt;

  assign wr_ready = (fill_r != FillW'(DEPTH));
  assign rd_valid = (fill_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + PtrW'(1);
    end
    case ({wr_en, rd_en})
      2'b10:   fill_nxt = fill_r + FillW'(1);
      2'b01:   fill_nxt = fill_r - FillW'(1);
      default: fill_nxt = fill_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

[rtl/cssim_back.sv]
// Back end: multiplies, divides and takes the root to form the rounded similarity.
module cssim_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_rd_valid,
  input  cssim_pkg::acc_set_t    q_rd_data,
  output logic                   q_rd_en,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [cssim_pkg::ResW-1:0] out_tdata,
  output logic                   out_tuser
);
  import cssim_pkg::*;

  back_state_t      state_r;
  back_state_t      state_nxt;
  logic [CntW-1:0]  cnt_r;
  logic [CntW-1:0]  cnt_nxt;
  logic [ProdW-1:0] acc_r;
  logic [ProdW-1:0] acc_nxt;
  logic [ProdW-1:0] cand_r;
  logic [ProdW-1:0] cand_nxt;
  logic [ProdW-1:0] num_r;
  logic [ProdW-1:0] num_nxt;
  logic [AccW-1:0]  plier_r;
  logic [AccW-1:0]  plier_nxt;
  logic [QuoW-1:0]  quo_r;
  logic [QuoW-1:0]  quo_nxt;
  logic [QuoW-1:0]  root_r;
  logic [QuoW-1:0]  root_nxt;
  logic             neg_r;
  logic             neg_nxt;
  logic             zero_r;
  logic             zero_nxt;
  logic             over_r;
  logic             over_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic [ResW-1:0]  out_sim_r;
  logic [ResW-1:0]  out_sim_nxt;
  logic             out_zero_r;
  logic             out_zero_nxt;

  logic             head_zero;
  logic [AccW-1:0]  dot_mag;
  logic [ProdW-1:0] mul_add;
  logic             mul_last;
  logic [ProdW-1:0] rem2;
  logic             div_ge;
  logic [ProdW-1:0] div_sub;
  logic [CntW-1:0]  sq_idx;
  logic [QuoW-1:0]  sq_one;
  logic [QuoW:0]    sq_trial;
  logic             sq_ge;
  logic [QuoW:0]    sq_diff;
  logic [RootW:0]   rnd_sum;
  logic [ResW-1:0]  rnd_mag;
  logic [ResW-1:0]  fin_sim;
  logic             out_free;
  logic             out_load;

  assign head_zero = (q_rd_data.sq_a == '0) || (q_rd_data.sq_b == '0);
  assign dot_mag   = q_rd_data.dot[AccW-1] ? (AccW'(0) - $unsigned(q_rd_data.dot))
                                           : $unsigned(q_rd_data.dot);

  assign mul_add  = acc_r + (plier_r[0] ? cand_r : '0);
  assign mul_last = (cnt_r == CntW'(AccW - 1));

  assign rem2    = {acc_r[ProdW-2:0], 1'b0};
  assign div_ge  = (rem2 >= cand_r);
  assign div_sub = rem2 - cand_r;

  assign sq_idx   = CntW'(RootW - 1) - cnt_r;
  assign sq_one   = QuoW'(1) << {sq_idx, 1'b0};
  assign sq_trial = (QuoW+1)'(root_r) + (QuoW+1)'(sq_one);
  assign sq_ge    = ((QuoW+1)'(quo_r) >= sq_trial);
  assign sq_diff  = (QuoW+1)'(quo_r) - sq_trial;

  assign rnd_sum = (RootW+1)'(root_r[RootW-1:0]) + (RootW+1)'(1);

  always_comb begin
    rnd_mag = over_r ? ResOne : rnd_sum[RootW:1];
    if (zero_r) begin
      fin_sim = '0;
    end else if (neg_r) begin
      fin_sim = ResW'(0) - rnd_mag;
    end else begin
      fin_sim = (rnd_mag > ResMax) ? ResMax : rnd_mag;
    end
  end

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (q_rd_valid) begin
          state_nxt = head_zero ? ST_FIN : ST_MUL_DOT;
        end
      end
      ST_MUL_DOT: begin
        if (mul_last) begin
          state_nxt = ST_MUL_NORM;
        end
      end
      ST_MUL_NORM: begin
        if (mul_last) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_nxt = (num_r >= cand_r) ? ST_FIN : ST_DIV;
      end
      ST_DIV: begin
        if (cnt_r == CntW'(QuoW - 1)) begin
          state_nxt = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (cnt_r == CntW'(RootW - 1)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    q_rd_en   = 1'b0;
    out_load  = 1'b0;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    cand_nxt  = cand_r;
    num_nxt   = num_r;
    plier_nxt = plier_r;
    quo_nxt   = quo_r;
    root_nxt  = root_r;
    neg_nxt   = neg_r;
    zero_nxt  = zero_r;
    over_nxt  = over_r;
    case (state_r)
      ST_IDLE: begin
        if (q_rd_valid) begin
          neg_nxt   = q_rd_data.dot[AccW-1];
          zero_nxt  = head_zero;
          over_nxt  = 1'b0;
          q_rd_en   = head_zero;
          acc_nxt   = '0;
          cand_nxt  = ProdW'(dot_mag);
          plier_nxt = dot_mag;
          cnt_nxt   = '0;
        end
      end
      ST_MUL_DOT, ST_MUL_NORM: begin
        acc_nxt   = mul_add;
        cand_nxt  = {cand_r[ProdW-2:0], 1'b0};
        plier_nxt = plier_r >> 1;
        cnt_nxt   = cnt_r + CntW'(1);
        if (mul_last) begin
          cnt_nxt = '0;
          if (state_r == ST_MUL_DOT) begin
            num_nxt   = mul_add;
            acc_nxt   = '0;
            cand_nxt  = ProdW'(q_rd_data.sq_a);
            plier_nxt = q_rd_data.sq_b;
          end else begin
            cand_nxt = mul_add;
            q_rd_en  = 1'b1;
          end
        end
      end
      ST_CHECK: begin
        over_nxt = (num_r >= cand_r);
        acc_nxt  = num_r;
        quo_nxt  = '0;
        root_nxt = '0;
        cnt_nxt  = '0;
      end
      ST_DIV: begin
        acc_nxt = div_ge ? div_sub : rem2;
        quo_nxt = {quo_r[QuoW-2:0], div_ge};
        cnt_nxt = (cnt_r == CntW'(QuoW - 1)) ? '0 : cnt_r + CntW'(1);
      end
      ST_SQRT: begin
        if (sq_ge) begin
          quo_nxt  = sq_diff[QuoW-1:0];
          root_nxt = (root_r >> 1) + sq_one;
        end else begin
          root_nxt = root_r >> 1;
        end
        cnt_nxt = cnt_r + CntW'(1);
      end
      ST_FIN: begin
        out_load = out_free;
      end
      default: begin
        cnt_nxt = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_sim_nxt   = out_sim_r;
    out_zero_nxt  = out_zero_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_sim_nxt   = fin_sim;
      out_zero_nxt  = zero_r;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_sim_r;
  assign out_tuser  = out_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    cand_r     <= cand_nxt;
    num_r      <= num_nxt;
    plier_r    <= plier_nxt;
    quo_r      <= quo_nxt;
    root_r     <= root_nxt;
    neg_r      <= neg_nxt;
    zero_r     <= zero_nxt;
    over_r     <= over_nxt;
    out_sim_r  <= out_sim_nxt;
    out_zero_r <= out_zero_nxt;
  end

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (acc_r < cand_r))
    else $error("Division remainder reached the divisor.");

  a_root_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && !zero_r && !over_r) |-> (root_r[QuoW-1:RootW] == '0))
    else $error("Square root exceeded its result width.");

  a_zero_norm_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata == '0))
    else $error("Zero norm item carries a nonzero similarity.");

  a_pop_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
    q_rd_en |-> q_rd_valid)
    else $error("Queue read while empty.");

endmodule

[rtl/cosine_similarity_stream_core.sv]
// Top level of the streaming cosine similarity core.
//
//   Channel | Ports                          | Item contents (low bit first)
//   input   | in_tvalid in_tready in_tdata   | first_element, second_element;
//           | in_tlast                       | last_pair on in_tlast
//   result  | out_tvalid out_tready out_tdata| similarity; zero_norm on out_tuser
//           | out_tuser                      |
//
// The front end takes one element pair per cycle unless a final pair waits on a full
// queue, and adds the registered products to the sums. The back end runs two 48-step
// shift-add multiplies, a 32-step restoring division and a 16-step square root, one step
// per cycle. Zero-norm vectors skip them all; those saturating at one skip the last two.
// Finished sums wait in a short queue, so input stalls only when that queue is full.
// Reset is synchronous and active low and leaves all sums at zero.
module cosine_similarity_stream_core #(
  parameter int SAMPLE_BITS = cssim_pkg::DefSampleBits,
  parameter int QUEUE_DEPTH = cssim_pkg::DefQueueDepth
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [cssim_pkg::InDataW-1:0] in_tdata,   // first_element, second_element
  input  logic                          in_tlast,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [cssim_pkg::ResW-1:0]    out_tdata,  // similarity
  output logic                          out_tuser   // zero_norm
);
  import cssim_pkg::*;

  logic     q_wr_en;
  logic     q_wr_ready;
  acc_set_t q_wr_data;
  logic     q_rd_en;
  logic     q_rd_valid;
  acc_set_t q_rd_data;

  cssim_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .q_wr_ready (q_wr_ready),
    .q_wr_en    (q_wr_en),
    .q_wr_data  (q_wr_data)
  );

  cssim_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (q_wr_en),
    .wr_data  (q_wr_data),
    .wr_ready (q_wr_ready),
    .rd_en    (q_rd_en),
    .rd_data  (q_rd_data),
    .rd_valid (q_rd_valid)
  );

  cssim_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_rd_valid (q_rd_valid),
    .q_rd_data  (q_rd_data),
    .q_rd_en    (q_rd_en),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
